FILE: hw/rtl/bma_pkg.sv
// Package for the bitmap allocator: operation codes, field widths and the
// command/status structs passed between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

    // Field widths of the stream payloads
    localparam int unsigned OP_W        = 3;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned CNT_W       = 9;   // num_bits and free_count
    localparam int unsigned BASE_W      = 10;  // bit base of a word, with headroom
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [CNT_W-1:0] NUM_BITS_RESET = 9'd256;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MARK  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;  // zero one word of the store
        logic start;       // capture request and size
        logic check;       // decide fast path, read first word
        logic scan_step;   // evaluate one word, read the next
        logic finish;      // move result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // last word of the clearing pass
        logic fast;        // result known without touching the store
        logic scan_done;   // current word ends the scan
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bma_ctrl.sv
// Controller state machine of the bitmap allocator.
// Depends on bma_pkg (dp_cmd_t, dp_status_t).
`timescale 1ns / 1ps
`default_nettype none

module bma_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire bma_pkg::dp_status_t status,
    output bma_pkg::dp_cmd_t         cmd
);
    import bma_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = status.fast ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Clearing pass runs once after reset only
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass re-entered");

    // A request is only taken in idle, never twice in a row
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !cmd.start && !s_tready)
        else $error("second request taken while busy");

    // Scanning never starts without a check of the request
    a_scan_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cmd.scan_step) |-> $past(cmd.check))
        else $error("scan entered without check");

endmodule

`default_nettype wire

FILE: hw/rtl/bma_datapath.sv
// Datapath of the bitmap allocator: word store, scan counters, word
// evaluation, size register and output register.
// Depends on bma_pkg (codes, widths, dp_cmd_t, dp_status_t).
`timescale 1ns / 1ps
`default_nettype none

module bma_datapath #(
    parameter int unsigned MAX_BITS  = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [bma_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [bma_pkg::CNT_W-1:0]         cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bma_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  wire bma_pkg::dp_cmd_t                  cmd,
    output bma_pkg::dp_status_t                    status
);
    import bma_pkg::*;

    localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned POS_W     = $clog2(WORD_BITS);
    localparam int unsigned PC_W      = $clog2(WORD_BITS + 1);

    // Word store
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    // Request and scan state
    logic [CNT_W-1:0]  num_bits_reg;
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [AW:0]       rd_word_reg;
    logic [AW-1:0]     ev_word_reg;
    logic [BASE_W-1:0] ev_base_reg;

    // Result registers
    logic             res_bit_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_ok_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic             res_err_reg;
    logic             m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // Combinational evaluation
    logic [CNT_W-1:0]     n_now;
    logic                 is_bitop;
    logic                 range_err;
    logic [BASE_W-1:0]    rem;
    logic                 last_word;
    logic [WORD_BITS-1:0] free_bits;
    logic                 any_free;
    logic [POS_W-1:0]     pos;
    logic [WORD_BITS-1:0] pos_oh;
    logic [BASE_W-1:0]    diff;
    logic [WORD_BITS-1:0] off_oh;
    logic                 hit;
    logic                 sel_bit;
    logic [PC_W-1:0]      pop;
    logic [BASE_W-1:0]    alloc_pos;

    // Bits in use, limited to the store size
    always_comb begin
        if (32'(num_bits_reg) > 32'(MAX_BITS)) begin
            n_now = CNT_W'(MAX_BITS);
        end else begin
            n_now = num_bits_reg;
        end
    end

    // Fast path decision on the captured request
    always_comb begin
        is_bitop  = (op_reg == OP_MARK) || (op_reg == OP_CLEAR) || (op_reg == OP_TEST);
        range_err = is_bitop && ({1'b0, idx_reg} >= n_reg);
    end

    // Evaluate the word held in the read register
    always_comb begin
        rem       = {1'b0, n_reg} - ev_base_reg;
        last_word = (rem <= BASE_W'(WORD_BITS));
        diff      = {2'b00, idx_reg} - ev_base_reg;
        hit       = ({2'b00, idx_reg} < (ev_base_reg + BASE_W'(WORD_BITS)));
        for (int b = 0; b < WORD_BITS; b++) begin
            free_bits[b] = !rdata_reg[b] && (BASE_W'(b) < rem);
            off_oh[b]    = (diff == BASE_W'(b));
        end
        any_free = |free_bits;
        sel_bit  = |(rdata_reg & off_oh);
        // lowest free bit
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                pos = POS_W'(b);
            end
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            pos_oh[b] = (pos == POS_W'(b));
        end
        pop = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            pop = pop + PC_W'(free_bits[b]);
        end
        alloc_pos = ev_base_reg + BASE_W'(pos);
    end

    // Status to the controller
    always_comb begin
        status.clear_last = (ev_word_reg == AW'(NUM_WORDS - 1));
        status.fast       = !is_bitop && (op_reg != OP_ALLOC) && (op_reg != OP_COUNT);
        if (range_err) begin
            status.fast = 1'b1;
        end
        if (((op_reg == OP_ALLOC) || (op_reg == OP_COUNT)) && (n_reg == '0)) begin
            status.fast = 1'b1;
        end
        case (op_reg) inside
            OP_MARK, OP_CLEAR, OP_TEST: status.scan_done = hit;
            OP_ALLOC:                   status.scan_done = any_free || last_word;
            OP_COUNT:                   status.scan_done = last_word;
            default:                    status.scan_done = 1'b1;
        endcase
        status.out_free = !m_tvalid_reg || m_tready;
    end

    // Store write and read port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ev_word_reg;
        mem_wdata = '0;
        if (cmd.clear_step) begin
            mem_we = 1'b1;
        end else if (cmd.scan_step) begin
            case (op_reg)
                OP_MARK: begin
                    mem_we    = hit;
                    mem_wdata = rdata_reg | off_oh;
                end
                OP_CLEAR: begin
                    mem_we    = hit;
                    mem_wdata = rdata_reg & ~off_oh;
                end
                OP_ALLOC: begin
                    mem_we    = any_free;
                    mem_wdata = rdata_reg | pos_oh;
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
        mem_re    = cmd.check || (cmd.scan_step && (rd_word_reg < (AW + 1)'(NUM_WORDS)));
        mem_raddr = cmd.check ? '0 : rd_word_reg[AW-1:0];
    end

    // Word store ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bits_reg <= NUM_BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            num_bits_reg <= cfg_data;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= s_tdata[OP_W-1:0];
            idx_reg <= s_tdata[OP_W+IDX_W-1:OP_W];
            n_reg   <= n_now;
        end
    end

    // Word counters; ev_word also walks the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_word_reg <= '0;
            rd_word_reg <= '0;
            ev_base_reg <= '0;
        end else if (cmd.clear_step) begin
            ev_word_reg <= ev_word_reg + 1'b1;
        end else if (cmd.check) begin
            ev_word_reg <= '0;
            rd_word_reg <= (AW + 1)'(1);
            ev_base_reg <= '0;
        end else if (cmd.scan_step) begin
            ev_word_reg <= ev_word_reg + 1'b1;
            rd_word_reg <= rd_word_reg + 1'b1;
            ev_base_reg <= ev_base_reg + BASE_W'(WORD_BITS);
        end
    end

    // Result accumulation
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            res_bit_reg <= 1'b0;
            res_idx_reg <= '0;
            res_ok_reg  <= 1'b0;
            res_cnt_reg <= '0;
            res_err_reg <= range_err;
        end else if (cmd.scan_step) begin
            if (is_bitop && hit) begin
                res_bit_reg <= sel_bit;
            end
            if ((op_reg == OP_ALLOC) && any_free) begin
                res_ok_reg  <= 1'b1;
                res_idx_reg <= alloc_pos[IDX_W-1:0];
            end
            if (op_reg == OP_COUNT) begin
                res_cnt_reg <= res_cnt_reg + CNT_W'(pop);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {4'b0000, res_err_reg, res_cnt_reg, res_ok_reg,
                            res_idx_reg, res_bit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A scan only evaluates words inside the store
    a_scan_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> ({1'b0, ev_word_reg} < (AW + 1)'(NUM_WORDS)))
        else $error("scan ran past the store");

    // Allocation success and range error never come together
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[9] && m_tdata_reg[19]))
        else $error("alloc_ok with range_error");

    // The output register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_allocator_unit.sv
// Bitmap allocator.
// Channels: s_ request stream (operation, bit_index), m_ result stream,
// cfg_ write channel for num_bits (always ready, write only while idle).
// Each request gives exactly one result. Operations: mark, clear, test,
// allocate lowest clear bit, count clear bits.
// Scan per request, from acceptance to result valid:
//   - range error, n = 0 for allocate/count, unused code: no scan
//   - mark/clear/test of bit i: words up to and including the one holding i
//   - allocate: words read up to and including the first one with a
//     free bit (all ceil(n / WORD_BITS) words when the map is full)
//   - count: all ceil(n / WORD_BITS) words are read
// The scan reads the word store once per cycle through its single read
// port. One request is in work at a time.
// Reset clears the size to 256, then a clearing pass zeroes all
// NUM_WORDS words of the store at one word per cycle, with s_tready low.
// A stalled receiver holds the result in the output register; one more
// request is taken and worked, and its result waits until that frees.
// Depends on bma_pkg, bma_ctrl, bma_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator_unit #(
    parameter int unsigned MAX_BITS  = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] operation, [10:3] bit_index, [15:11] zero
    input  wire logic [bma_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] bit_value, [8:1] alloc_index, [9] alloc_ok, [18:10] free_count,
    // [19] range_error, [23:20] zero
    output logic [bma_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // size register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bma_pkg::CNT_W-1:0]         cfg_data
);
    import bma_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Controller
    bma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    bma_datapath #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
